// ----- src/softcode_expression_tokenizer_macros.svh -----
// Assertion macros shared by the tokenizer modules.
`ifndef SOFTCODE_EXPRESSION_TOKENIZER_MACROS_SVH
`define SOFTCODE_EXPRESSION_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SXTOK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sxtok assertion failed");

// Next-cycle implication, checked outside reset.
`define SXTOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sxtok assertion failed");

`endif

// ----- src/sxtok_pkg.sv -----
package sxtok_pkg;

   localparam int unsigned LINE_MAX = 8192;
   localparam int unsigned POS_W    = $clog2(LINE_MAX);
   localparam int unsigned OUT_W    = 13;
   localparam int unsigned RQ_DEPTH = 4;
   localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   typedef logic [POS_W-1:0] pos_type;

   localparam pos_type POS_MAX = pos_type'(LINE_MAX - 1);

   // token kinds
   localparam logic [3:0] K_LIT    = 4'd0;
   localparam logic [3:0] K_FUNC   = 4'd1;
   localparam logic [3:0] K_LPAREN = 4'd2;
   localparam logic [3:0] K_RPAREN = 4'd3;
   localparam logic [3:0] K_LBRACK = 4'd4;
   localparam logic [3:0] K_RBRACK = 4'd5;
   localparam logic [3:0] K_LBRACE = 4'd6;
   localparam logic [3:0] K_RBRACE = 4'd7;
   localparam logic [3:0] K_COMMA  = 4'd8;
   localparam logic [3:0] K_SEMI   = 4'd9;
   localparam logic [3:0] K_PCT    = 4'd10;
   localparam logic [3:0] K_ESC    = 4'd11;
   localparam logic [3:0] K_SPACE  = 4'd12;
   localparam logic [3:0] K_END    = 4'd13;

   // lexer modes
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_LIT     = 4'd1;
   localparam logic [3:0] M_SPACE   = 4'd2;
   localparam logic [3:0] M_PCT     = 4'd3;
   localparam logic [3:0] M_PCT_SEL = 4'd4;
   localparam logic [3:0] M_PCT_V   = 4'd5;
   localparam logic [3:0] M_PCT_EQ  = 4'd6;
   localparam logic [3:0] M_PCT_I   = 4'd7;
   localparam logic [3:0] M_ANGLE   = 4'd8;
   localparam logic [3:0] M_ESC     = 4'd9;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_GT     = 8'h3e;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UC     = 8'h43;
   localparam logic [7:0] CH_UI     = 8'h49;
   localparam logic [7:0] CH_UQ     = 8'h51;
   localparam logic [7:0] CH_UV     = 8'h56;
   localparam logic [7:0] CH_UX     = 8'h58;
   localparam logic [7:0] CH_UZ     = 8'h5a;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7a;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   typedef struct packed {
      logic [3:0]       kind;
      logic [OUT_W-1:0] start;
      logic [OUT_W-1:0] length;
      logic             last;
   } result_type;

   typedef struct packed {
      logic       v0;
      logic       v1;
      result_type r0;
      result_type r1;
   } push_type;

   function automatic pos_type sat_inc(input pos_type v);
      return (v < POS_MAX) ? pos_type'(v + 1'b1) : POS_MAX;
   endfunction

   function automatic logic [OUT_W-1:0] to_field(input pos_type v);
      return OUT_W'(v);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) ? 8'(c - CASE_GAP) : c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK
          || c == CH_LBRACE || c == CH_RBRACE || c == CH_COMMA || c == CH_SEMI;
   endfunction

   function automatic logic [3:0] single_kind(input logic [7:0] c);
      logic [3:0] k;
      unique case (c)
         CH_LPAREN: k = K_LPAREN;
         CH_RPAREN: k = K_RPAREN;
         CH_LBRACK: k = K_LBRACK;
         CH_RBRACK: k = K_RBRACK;
         CH_LBRACE: k = K_LBRACE;
         CH_RBRACE: k = K_RBRACE;
         CH_COMMA:  k = K_COMMA;
         CH_SEMI:   k = K_SEMI;
         default:   k = K_LIT;
      endcase
      return k;
   endfunction

   function automatic logic ends_literal(input logic [7:0] c);
      return is_single(c) || c == CH_PCT || c == CH_BSLASH || is_blank(c);
   endfunction

   function automatic logic [3:0] open_kind(input logic [3:0] m);
      logic [3:0] k;
      unique case (m)
         M_LIT:   k = K_LIT;
         M_SPACE: k = K_SPACE;
         M_ESC:   k = K_ESC;
         default: k = K_PCT;
      endcase
      return k;
   endfunction

endpackage

// ----- src/sxtok_lexer.sv -----
`include "softcode_expression_tokenizer_macros.svh"

module sxtok_lexer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [7:0]         req_ch,
   input  logic               q_room,
   output sxtok_pkg::push_type push
);

   localparam int unsigned OUT_W_L = sxtok_pkg::OUT_W;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_kind_ff;
   logic [7:0]          s1_ch_ff;
   logic [3:0]          mode_ff, mode_in;
   sxtok_pkg::pos_type  start_ff, start_in;
   sxtok_pkg::pos_type  len_ff, len_in;
   sxtok_pkg::pos_type  pos_ff, pos_in;
   logic                adv;
   logic                take_in;

   logic                e0_v, e1_v, fresh;
   logic [3:0]          e0_k, e1_k;
   sxtok_pkg::pos_type  e0_len, len_inc;
   logic [OUT_W_L-1:0]  e1_len;
   sxtok_pkg::pos_type  e1_start;
   logic [7:0]          c, u;
   sxtok_pkg::result_type res0, res1;
   logic                eol_adv;
   logic                end_sent;

   assign adv         = s1_valid_ff && q_room;
   assign req_ready   = !s1_valid_ff || q_room;
   assign take_in     = req_valid && req_ready;
   assign s1_valid_in = take_in || (s1_valid_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (take_in) begin
         s1_kind_ff <= req_kind;
         s1_ch_ff   <= req_ch;
      end
   end

   always_comb begin
      c        = s1_ch_ff;
      u        = sxtok_pkg::to_upper(s1_ch_ff);
      len_inc  = sxtok_pkg::sat_inc(len_ff);
      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      e0_v     = 1'b0;
      e0_k     = sxtok_pkg::K_LIT;
      e0_len   = len_ff;
      e1_v     = 1'b0;
      e1_k     = sxtok_pkg::K_END;
      e1_start = pos_ff;
      e1_len   = '0;
      fresh    = 1'b0;

      if (s1_kind_ff == sxtok_pkg::KIND_EOL) begin
         e0_v     = mode_ff != sxtok_pkg::M_IDLE;
         e0_k     = sxtok_pkg::open_kind(mode_ff);
         e1_v     = 1'b1;
         mode_in  = sxtok_pkg::M_IDLE;
         start_in = '0;
         len_in   = '0;
         pos_in   = '0;
      end else begin
         unique case (mode_ff)
            sxtok_pkg::M_LIT: begin
               if (sxtok_pkg::ends_literal(c)) begin
                  e0_v    = 1'b1;
                  e0_k    = (c == sxtok_pkg::CH_LPAREN) ? sxtok_pkg::K_FUNC : sxtok_pkg::K_LIT;
                  mode_in = sxtok_pkg::M_IDLE;
                  fresh   = 1'b1;
               end else begin
                  len_in = len_inc;
               end
            end
            sxtok_pkg::M_SPACE: begin
               if (sxtok_pkg::is_blank(c)) begin
                  len_in = len_inc;
               end else begin
                  e0_v    = 1'b1;
                  e0_k    = sxtok_pkg::K_SPACE;
                  mode_in = sxtok_pkg::M_IDLE;
                  fresh   = 1'b1;
               end
            end
            sxtok_pkg::M_PCT: begin
               len_in = len_inc;
               if (u == sxtok_pkg::CH_UQ || u == sxtok_pkg::CH_UC
                   || u == sxtok_pkg::CH_UX) begin
                  mode_in = sxtok_pkg::M_PCT_SEL;
               end else if (u == sxtok_pkg::CH_UV) begin
                  mode_in = sxtok_pkg::M_PCT_V;
               end else if (c == sxtok_pkg::CH_EQ) begin
                  mode_in = sxtok_pkg::M_PCT_EQ;
               end else if (u == sxtok_pkg::CH_UI) begin
                  mode_in = sxtok_pkg::M_PCT_I;
               end else begin
                  e0_v    = 1'b1;
                  e0_k    = sxtok_pkg::K_PCT;
                  e0_len  = len_inc;
                  mode_in = sxtok_pkg::M_IDLE;
               end
            end
            sxtok_pkg::M_PCT_SEL: begin
               len_in = len_inc;
               if (c == sxtok_pkg::CH_LT) begin
                  mode_in = sxtok_pkg::M_ANGLE;
               end else begin
                  e0_v    = 1'b1;
                  e0_k    = sxtok_pkg::K_PCT;
                  e0_len  = len_inc;
                  mode_in = sxtok_pkg::M_IDLE;
               end
            end
            sxtok_pkg::M_PCT_V: begin
               e0_v    = 1'b1;
               e0_k    = sxtok_pkg::K_PCT;
               mode_in = sxtok_pkg::M_IDLE;
               if (sxtok_pkg::is_alpha(c)) begin
                  e0_len = len_inc;
               end else begin
                  fresh = 1'b1;
               end
            end
            sxtok_pkg::M_PCT_EQ: begin
               if (c == sxtok_pkg::CH_LT) begin
                  len_in  = len_inc;
                  mode_in = sxtok_pkg::M_ANGLE;
               end else begin
                  e0_v    = 1'b1;
                  e0_k    = sxtok_pkg::K_PCT;
                  mode_in = sxtok_pkg::M_IDLE;
                  fresh   = 1'b1;
               end
            end
            sxtok_pkg::M_PCT_I: begin
               e0_v    = 1'b1;
               e0_k    = sxtok_pkg::K_PCT;
               mode_in = sxtok_pkg::M_IDLE;
               if (sxtok_pkg::is_digit(c)) begin
                  e0_len = len_inc;
               end else begin
                  fresh = 1'b1;
               end
            end
            sxtok_pkg::M_ANGLE: begin
               len_in = len_inc;
               if (c == sxtok_pkg::CH_GT) begin
                  e0_v    = 1'b1;
                  e0_k    = sxtok_pkg::K_PCT;
                  e0_len  = len_inc;
                  mode_in = sxtok_pkg::M_IDLE;
               end
            end
            sxtok_pkg::M_ESC: begin
               e0_v    = 1'b1;
               e0_k    = sxtok_pkg::K_ESC;
               e0_len  = len_inc;
               mode_in = sxtok_pkg::M_IDLE;
            end
            default: begin
               mode_in = sxtok_pkg::M_IDLE;
               fresh   = 1'b1;
            end
         endcase

         if (fresh) begin
            if (sxtok_pkg::is_single(c)) begin
               e1_v   = 1'b1;
               e1_k   = sxtok_pkg::single_kind(c);
               e1_len = OUT_W_L'(1);
            end else begin
               start_in = pos_ff;
               len_in   = sxtok_pkg::pos_type'(1);
               if (c == sxtok_pkg::CH_PCT) begin
                  mode_in = sxtok_pkg::M_PCT;
               end else if (c == sxtok_pkg::CH_BSLASH) begin
                  mode_in = sxtok_pkg::M_ESC;
               end else if (sxtok_pkg::is_blank(c)) begin
                  mode_in = sxtok_pkg::M_SPACE;
               end else begin
                  mode_in = sxtok_pkg::M_LIT;
               end
            end
         end
         pos_in = sxtok_pkg::sat_inc(pos_ff);
      end

      res0.kind   = e0_k;
      res0.start  = sxtok_pkg::to_field(start_ff);
      res0.length = sxtok_pkg::to_field(e0_len);
      res0.last   = !e1_v;
      res1.kind   = e1_k;
      res1.start  = sxtok_pkg::to_field(e1_start);
      res1.length = e1_len;
      res1.last   = 1'b1;

      push.v0 = adv && (e0_v || e1_v);
      push.v1 = adv && e0_v && e1_v;
      push.r0 = e0_v ? res0 : res1;
      push.r1 = res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sxtok_pkg::M_IDLE;
         start_ff <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else if (adv) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

   assign eol_adv  = adv && s1_kind_ff == sxtok_pkg::KIND_EOL;
   assign end_sent = push.v0 && (push.v1 ? push.r1.kind == sxtok_pkg::K_END
                                         : push.r0.kind == sxtok_pkg::K_END);

   `SXTOK_ASSERT_NEXT(a_eol_clears, clock, reset, eol_adv, mode_ff == sxtok_pkg::M_IDLE && pos_ff == '0)
   `SXTOK_ASSERT_NOW(a_eol_ends_run, clock, reset, eol_adv, end_sent)

endmodule

// ----- src/sxtok_rsp_queue.sv -----
`include "softcode_expression_tokenizer_macros.svh"

module sxtok_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  sxtok_pkg::push_type   push,
   output logic                  q_room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sxtok_pkg::result_type rsp_word
);

   localparam int unsigned PW = sxtok_pkg::RQ_PTR_W;
   localparam int unsigned CW = sxtok_pkg::RQ_CNT_W;

   sxtok_pkg::result_type entry_ff [sxtok_pkg::RQ_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;
   logic          pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign q_room    = count_ff <= CW'(sxtok_pkg::RQ_DEPTH - 2);
   assign wr_next   = PW'(wr_ptr_ff + 1'b1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.v1) begin
         wr_ptr_in = PW'(wr_ptr_ff + 2'd2);
      end else if (push.v0) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CW'(count_ff + CW'(push.v0) + CW'(push.v1) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.v0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.v1) begin
         entry_ff[wr_next] <= push.r1;
      end
   end

   `SXTOK_ASSERT_NOW(a_pair_order, clock, reset, push.v1, push.v0)
   `SXTOK_ASSERT_NOW(a_push_has_room, clock, reset, push.v0, q_room)
   `SXTOK_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push.v0, count_ff == CW'($past(count_ff) - 1'b1))

endmodule

// ----- src/softcode_expression_tokenizer.sv -----
// Streaming tokenizer for softcode expression lines. Each input word is one line byte or
// an end-of-line mark; each result word is one token (kind, start offset, length) with
// last_of_run set on the final token an input word causes. A byte is registered, then lexed
// combinationally against the mode, open-token and position registers, and its tokens are
// written to a four-word result queue whose head entry drives the result port. Input
// is taken every cycle while the queue has room for two tokens, so the sustained rate is one
// byte per cycle, bounded only by the result port draining one token per cycle: a byte that
// closes one token and opens a single-character one, or an end of line with a token open,
// puts two tokens on the result port. Offsets and lengths saturate at LINE_MAX-1.
module softcode_expression_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [12:0] rsp_token_start,
   output logic [12:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   sxtok_pkg::push_type   push;
   sxtok_pkg::result_type rsp_word;
   logic                  q_room;

   sxtok_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_ch    (req_ch),
      .q_room    (q_room),
      .push      (push)
   );

   sxtok_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .q_room    (q_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_token_kind   = rsp_word.kind;
   assign rsp_token_start  = rsp_word.start;
   assign rsp_token_length = rsp_word.length;
   assign rsp_last_of_run  = rsp_word.last;

endmodule

// ----- bench/sxtok_token_checker.sv -----
`timescale 1ns / 1ps
module sxtok_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_ch,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_token_kind,
   input  logic [12:0] rsp_token_start,
   input  logic [12:0] rsp_token_length,
   input  logic        rsp_last_of_run,
   output int          mismatches,
   output int          pending,
   output int          tokens_seen
);
   import sxtok_pkg::*;

   logic [3:0] lex_mode;
   pos_type    tok_start;
   pos_type    tok_len;
   pos_type    line_pos;

   result_type word_toks [2];
   int         word_n;
   result_type tokens_due [$];
   result_type want;

   function automatic pos_type step_sat(input pos_type v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   // {hit, kind} for the one-byte tokens
   function automatic logic [4:0] punct_of(input logic [7:0] c);
      case (c)
         CH_LPAREN: return {1'b1, K_LPAREN};
         CH_RPAREN: return {1'b1, K_RPAREN};
         CH_LBRACK: return {1'b1, K_LBRACK};
         CH_RBRACK: return {1'b1, K_RBRACK};
         CH_LBRACE: return {1'b1, K_LBRACE};
         CH_RBRACE: return {1'b1, K_RBRACE};
         CH_COMMA:  return {1'b1, K_COMMA};
         CH_SEMI:   return {1'b1, K_SEMI};
         default:   return 5'd0;
      endcase
   endfunction

   function automatic logic blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   task automatic put_tok(input logic [3:0] k, input pos_type s, input pos_type n);
      word_toks[word_n] = '{kind: k, start: s, length: n, last: 1'b0};
      word_n++;
   endtask

   task automatic close_tok(input logic [3:0] k);
      put_tok(k, tok_start, tok_len);
      lex_mode = M_IDLE;
   endtask

   task automatic open_fresh(input logic [7:0] c);
      logic [4:0] p;
      p = punct_of(c);
      if (p[4]) begin
         put_tok(p[3:0], line_pos, pos_type'(1));
      end else begin
         tok_start = line_pos;
         tok_len   = pos_type'(1);
         if (c == CH_PCT) lex_mode = M_PCT;
         else if (c == CH_BSLASH) lex_mode = M_ESC;
         else if (blank(c)) lex_mode = M_SPACE;
         else lex_mode = M_LIT;
      end
   endtask

   task automatic lex_char(input logic [7:0] c);
      logic [7:0] up;
      logic       restart;
      logic [4:0] p;
      up      = (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
      restart = 1'b0;
      p       = punct_of(c);
      case (lex_mode)
         M_LIT: begin
            if (p[4] || c == CH_PCT || c == CH_BSLASH || blank(c)) begin
               close_tok(c == CH_LPAREN ? K_FUNC : K_LIT);
               restart = 1'b1;
            end else begin
               tok_len = step_sat(tok_len);
            end
         end
         M_SPACE: begin
            if (blank(c)) begin
               tok_len = step_sat(tok_len);
            end else begin
               close_tok(K_SPACE);
               restart = 1'b1;
            end
         end
         M_PCT: begin
            tok_len = step_sat(tok_len);
            if (up == CH_UQ || up == CH_UC || up == CH_UX) lex_mode = M_PCT_SEL;
            else if (up == CH_UV) lex_mode = M_PCT_V;
            else if (c == CH_EQ) lex_mode = M_PCT_EQ;
            else if (up == CH_UI) lex_mode = M_PCT_I;
            else close_tok(K_PCT);
         end
         M_PCT_SEL: begin
            tok_len = step_sat(tok_len);
            if (c == CH_LT) lex_mode = M_ANGLE;
            else close_tok(K_PCT);
         end
         M_PCT_V: begin
            if ((up >= CH_UA && up <= CH_UZ)) begin
               tok_len = step_sat(tok_len);
               close_tok(K_PCT);
            end else begin
               close_tok(K_PCT);
               restart = 1'b1;
            end
         end
         M_PCT_EQ: begin
            if (c == CH_LT) begin
               tok_len  = step_sat(tok_len);
               lex_mode = M_ANGLE;
            end else begin
               close_tok(K_PCT);
               restart = 1'b1;
            end
         end
         M_PCT_I: begin
            if (c >= CH_0 && c <= CH_9) begin
               tok_len = step_sat(tok_len);
               close_tok(K_PCT);
            end else begin
               close_tok(K_PCT);
               restart = 1'b1;
            end
         end
         M_ANGLE: begin
            tok_len = step_sat(tok_len);
            if (c == CH_GT) close_tok(K_PCT);
         end
         M_ESC: begin
            tok_len = step_sat(tok_len);
            close_tok(K_ESC);
         end
         default: begin
            lex_mode = M_IDLE;
            restart  = 1'b1;
         end
      endcase
      if (restart) open_fresh(c);
      line_pos = step_sat(line_pos);
   endtask

   task automatic clear_line();
      lex_mode  = M_IDLE;
      tok_start = '0;
      tok_len   = '0;
      line_pos  = '0;
   endtask

   task automatic end_line();
      case (lex_mode)
         M_IDLE:  ;
         M_LIT:   close_tok(K_LIT);
         M_SPACE: close_tok(K_SPACE);
         M_ESC:   close_tok(K_ESC);
         default: close_tok(K_PCT);
      endcase
      put_tok(K_END, line_pos, '0);
      clear_line();
   endtask

   task automatic predict_tokens(input logic k, input logic [7:0] c);
      result_type t;
      word_n = 0;
      if (k == KIND_EOL) end_line();
      else lex_char(c);
      for (int i = 0; i < word_n; i++) begin
         t          = word_toks[i];
         t.last     = (i == word_n - 1);
         tokens_due = {tokens_due, t};
         pending++;
      end
   endtask

   task automatic compare_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         tokens_due.delete();
         pending     = 0;
         mismatches  = 0;
         tokens_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            tokens_seen++;
            if (tokens_due.size() == 0) begin
               $error("token_kind: expected none, got %0d (start %0d)",
                      rsp_token_kind, rsp_token_start);
               mismatches++;
            end else begin
               want = tokens_due.pop_front();
               pending--;
               compare_field("token_kind", want.kind, rsp_token_kind);
               compare_field("token_start", want.start, rsp_token_start);
               compare_field("token_length", want.length, rsp_token_length);
               compare_field("last_of_run", want.last, rsp_last_of_run);
            end
         end
         if (req_valid && req_ready) predict_tokens(req_kind, req_ch);
      end
   end

endmodule

// ----- bench/tb_softcode_expression_tokenizer.sv -----
`timescale 1ns / 1ps
module tb_softcode_expression_tokenizer;
   import sxtok_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int WORD_TARGET = 2000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [7:0]  req_ch;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_token_kind;
   logic [12:0] rsp_token_start;
   logic [12:0] rsp_token_length;
   logic        rsp_last_of_run;

   int          mismatches;
   int          pending;
   int          tokens_seen;
   int          words_sent;
   int          lines_sent;
   int          stall_cycles;
   bit          gaps_on;
   logic [7:0]  line_bytes [$];

   softcode_expression_tokenizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   sxtok_token_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run),
      .mismatches       (mismatches),
      .pending          (pending),
      .tokens_seen      (tokens_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 10);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_word(input logic k, input logic [7:0] c);
      while (gaps_on && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         req_ch    <= 8'($urandom_range(0, 255));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= k;
      req_ch    <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_eol();
      send_word(KIND_EOL, 8'($urandom_range(0, 255)));
      lines_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(KIND_CHAR, s[i]);
   endtask

   task automatic append_byte(input logic [7:0] c);
      line_bytes = {line_bytes, c};
   endtask

   // byte that carries a literal on
   function automatic logic [7:0] lit_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK ||
             c == CH_LBRACE || c == CH_RBRACE || c == CH_COMMA || c == CH_SEMI ||
             c == CH_PCT || c == CH_BSLASH || c == CH_SPACE || c == CH_TAB);
      return c;
   endfunction

   function automatic logic [7:0] any_case(input logic [7:0] up);
      return $urandom_range(0, 1) ? up + CASE_GAP : up;
   endfunction

   task automatic add_angle_name();
      logic [7:0] c;
      append_byte(CH_LT);
      repeat ($urandom_range(0, 5)) begin
         do c = 8'($urandom_range(0, 255)); while (c == CH_GT);
         append_byte(c);
      end
      if ($urandom_range(0, 5) != 0) append_byte(CH_GT);
   endtask

   task automatic add_token();
      logic [7:0] puncts [8];
      logic [7:0] sels [3];
      puncts = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
                 CH_LBRACE, CH_RBRACE, CH_COMMA, CH_SEMI};
      sels   = '{CH_UQ, CH_UC, CH_UX};
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: begin
            repeat ($urandom_range(1, 6)) append_byte(lit_byte());
            if ($urandom_range(0, 2) == 0) append_byte(CH_LPAREN);
         end
         5, 6: begin
            repeat ($urandom_range(1, 3))
               append_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         end
         7, 8: append_byte(puncts[$urandom_range(0, 7)]);
         9: begin
            append_byte(CH_PCT);
            append_byte(8'(CH_0 + $urandom_range(0, 9)));
         end
         10, 11: begin
            append_byte(CH_PCT);
            append_byte(any_case(sels[$urandom_range(0, 2)]));
            add_angle_name();
         end
         12: begin
            append_byte(CH_PCT);
            append_byte(any_case(sels[$urandom_range(0, 2)]));
            append_byte(8'($urandom_range(0, 255)));
         end
         13: begin
            append_byte(CH_PCT);
            append_byte(any_case(CH_UV));
            if ($urandom_range(0, 2) != 0)
               append_byte(any_case(8'(CH_UA + $urandom_range(0, 25))));
            else
               append_byte(8'($urandom_range(0, 255)));
         end
         14: begin
            append_byte(CH_PCT);
            append_byte(CH_EQ);
            if ($urandom_range(0, 2) != 0) add_angle_name();
         end
         15: begin
            append_byte(CH_PCT);
            append_byte(any_case(CH_UI));
            if ($urandom_range(0, 2) != 0)
               append_byte(8'(CH_0 + $urandom_range(0, 9)));
            else
               append_byte(8'($urandom_range(0, 255)));
         end
         16: begin
            append_byte(CH_PCT);
            append_byte(8'($urandom_range(0, 255)));
         end
         17: begin
            append_byte(CH_BSLASH);
            append_byte(8'($urandom_range(0, 255)));
         end
         default: append_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_kind  = KIND_CHAR;
      req_ch    = 8'h00;
      gaps_on   = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty line, one-byte tokens, function name, loose ends at end of line
      send_eol();
      send_text("f([]{},;\t)");
      send_eol();
      send_text("%");
      send_eol();
      send_text("\\");
      send_eol();
      send_text("%q<a");
      send_eol();
      send_word(KIND_CHAR, 8'h00);
      send_word(KIND_CHAR, 8'hff);
      send_eol();

      while (words_sent < WORD_TARGET) begin
         gaps_on = !(words_sent > 800 && words_sent < 1200);
         line_bytes.delete();
         repeat ($urandom_range(0, 12)) add_token();
         foreach (line_bytes[i]) send_word(KIND_CHAR, line_bytes[i]);
         send_eol();
      end
      gaps_on = 1'b1;
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Lexed %0d words over %0d lines of mixed tokens and substitutions;",
               words_sent, lines_sent);
      $display("%0d tokens compared against the prediction.", tokens_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- softcode_expression_tokenizer.f -----
+incdir+src
src/sxtok_pkg.sv
src/sxtok_lexer.sv
src/sxtok_rsp_queue.sv
src/softcode_expression_tokenizer.sv
bench/sxtok_token_checker.sv
bench/tb_softcode_expression_tokenizer.sv
